[sv/chained_hash_table_engine_assert.svh]
// Assertion macros for the chained hash table engine.
// Depends on nothing; the using module supplies clock and reset in scope.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define CHT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cht assertion failed");
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cht assertion failed");
`else
`define CHT_ASSERT(lbl, prop)
`define CHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/cht_pkg.sv]
// Shared types and constants for the chained hash table engine.
// No dependencies.
`default_nettype none

package cht_pkg;

   localparam int CFG_W          = 9;
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
   localparam int OLDV_W         = 32;
   localparam int CNT_OUT_W      = 11;
   localparam int RSP_W          = 48;

   localparam int NUM_BUCKETS_DEF = 256;
   localparam int WAYS_DEF        = 4;
   localparam int KEY_BITS_DEF    = 32;
   localparam int VALUE_BITS_DEF  = 32;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic fill_rd;
      logic slot_rd;
      logic sel_last;
      logic way_inc;
      logic hit;
      logic wr_val;
      logic wr_new;
      logic wr_move;
      logic set_full;
      logic clear_all;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic   div_done;
      logic   scan_end;
      logic   match;
      logic   fill_full;
      op_type op;
   } sts_type;

endpackage

`default_nettype wire

[sv/chained_hash_table_engine.sv]
// Chained hash table engine: bounded separate-chaining key/value store.
// Channels: req (tuser = op, tdata = key, value) in; rsp (tdata = found,
// old_value, entry_count; tuser = status) out; csr_wr_en/csr_wr_data set the
// bucket count (key mod count picks the bucket), to be written only while idle;
// the block does not enforce this. Every word yields exactly one response word.
// Flow: clear goes through the clear state straight to the response; get/put/remove
// run the bit-serial remainder unit, one key bit per cycle, then scan the bucket's
// slots, one slot read and compare at a time, with one more step on a miss or a
// remove hit. The next word is taken in the cycle after the response loads.
// One word is worked on at a time; a new word is taken once the previous
// result sits in the output register, even while that result is stalled.
// A stalled receiver holds the response and blocks the next result only.
// Reset empties all buckets at once (per-bucket valid bits) and sets the
// bucket count to 256; slot contents are not cleared.
// Depends on cht_pkg, cht_ctrl and cht_dpath.
`default_nettype none

module chained_hash_table_engine import cht_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int WAYS        = WAYS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_wr_en,
   input  wire  [CFG_W-1:0]       csr_wr_data,   // bucket_count
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] req_tdata, // key, value, zero pad
   input  wire  [1:0]             req_tuser,     // op
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,     // found, old_value, entry_count, zero pad
   output logic [0:0]             rsp_tuser      // status
);

   logic [CFG_W-1:0]     bucket_count_ff;
   cmd_type              cmd;
   sts_type              sts;
   logic                 found;
   logic [OLDV_W-1:0]    old_value;
   logic                 status;
   logic [CNT_OUT_W-1:0] entry_count;

   always_ff @(posedge clock) begin
      if (reset) bucket_count_ff <= CFG_RESET;
      else if (csr_wr_en) bucket_count_ff <= csr_wr_data;
   end

   cht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   cht_dpath #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .WAYS        (WAYS),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg_bucket_count (bucket_count_ff),
      .in_op            (op_type'(req_tuser)),
      .in_key           (req_tdata[KEY_BITS-1:0]),
      .in_value         (req_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
      .out_found        (found),
      .out_old_value    (old_value),
      .out_status       (status),
      .out_entry_count  (entry_count)
   );

   assign rsp_tdata = RSP_W'({entry_count, old_value, found});
   assign rsp_tuser = status;

endmodule

`default_nettype wire

[sv/cht_ctrl.sv]
// Sequencer for the hash table engine: handshake and per-word command flow.
// Depends on cht_pkg.
`default_nettype none

module cht_ctrl import cht_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_tvalid,
   output logic    req_tready,
   input  op_type  req_op,
   output logic    rsp_tvalid,
   input  wire     rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_LOOK,
      S_CMP,
      S_MOVE,
      S_CLR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_CLEAR) ? S_CLR : S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.fill_rd = 1'b1;
               state_in    = S_LOOK;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_LOOK: begin
            if (sts.scan_end) begin
               // miss: put appends unless the bucket is full
               if (sts.op == OP_PUT) begin
                  if (sts.fill_full) cmd.set_full = 1'b1;
                  else               cmd.wr_new   = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               cmd.slot_rd = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.hit = 1'b1;
               case (sts.op)
                  OP_PUT: begin
                     cmd.wr_val = 1'b1;
                     state_in   = S_DONE;
                  end
                  OP_REMOVE: begin
                     cmd.slot_rd  = 1'b1;
                     cmd.sel_last = 1'b1;
                     state_in     = S_MOVE;
                  end
                  default: state_in = S_DONE;
               endcase
            end else begin
               cmd.way_inc = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_MOVE: begin
            cmd.wr_move = 1'b1;
            state_in    = S_DONE;
         end
         S_CLR: begin
            cmd.clear_all = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) rsp_tvalid_in = 1'b0;
      if (cmd.out_load) rsp_tvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

[sv/cht_dpath.sv]
// Datapath: bit-serial key remainder, bucket fill store, slot memories, result word.
// Depends on cht_pkg and the assertion macro header.
`default_nettype none
`include "chained_hash_table_engine_assert.svh"

module cht_dpath import cht_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
   parameter int WAYS        = WAYS_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  wire  [CFG_W-1:0]       cfg_bucket_count,
   input  op_type                 in_op,
   input  wire  [KEY_BITS-1:0]    in_key,
   input  wire  [VALUE_BITS-1:0]  in_value,
   output logic                   out_found,
   output logic [OLDV_W-1:0]      out_old_value,
   output logic                   out_status,
   output logic [CNT_OUT_W-1:0]   out_entry_count
);

   localparam int SLOTS  = NUM_BUCKETS * WAYS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(KEY_BITS + 1);

   logic [KEY_BITS-1:0]   key_mem [SLOTS];
   logic [VALUE_BITS-1:0] val_mem [SLOTS];
   logic [FILL_W-1:0]     fill_mem [NUM_BUCKETS];
   logic                  fill_vld_ff [NUM_BUCKETS];

   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff, key_sh_ff, key_rd_ff;
   logic [VALUE_BITS-1:0] val_ff, val_rd_ff, old_ff;
   logic [CFG_W-1:0]      rem_ff, rem_in, div_ff, eff_div;
   logic [CNT_W-1:0]      bit_cnt_ff;
   logic [FILL_W-1:0]     fill_rd_ff, fill_cur, way_ff;
   logic                  fill_rd_vld_ff;
   logic                  found_ff, status_ff;
   logic [TOT_W-1:0]      total_ff;
   logic [CFG_W:0]        trial;
   logic [BKT_W-1:0]      bucket;
   logic [31:0]           base;
   logic [SLOT_W-1:0]     slot_way, slot_fill, slot_last, rd_addr, wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;

   always_comb begin
      eff_div = cfg_bucket_count;
      if (cfg_bucket_count == '0) eff_div = CFG_W'(1);
      else if (32'(cfg_bucket_count) > NUM_BUCKETS) eff_div = CFG_W'(NUM_BUCKETS);
   end

   // restoring remainder, one key bit per cycle, msb first
   assign trial  = {rem_ff, key_sh_ff[KEY_BITS-1]};
   assign rem_in = (trial >= {1'b0, div_ff}) ? CFG_W'(trial - {1'b0, div_ff})
                                             : CFG_W'(trial);

   assign bucket    = BKT_W'(rem_ff);
   assign fill_cur  = fill_rd_vld_ff ? fill_rd_ff : '0;
   assign base      = 32'(bucket) * WAYS;
   assign slot_way  = SLOT_W'(base + 32'(way_ff));
   assign slot_fill = SLOT_W'(base + 32'(fill_cur));
   assign slot_last = SLOT_W'(base + 32'(fill_cur) - 32'd1);
   assign rd_addr   = cmd.sel_last ? slot_last : slot_way;
   assign wr_addr   = cmd.wr_new ? slot_fill : slot_way;
   assign wr_key    = cmd.wr_move ? key_rd_ff : key_ff;
   assign wr_value  = cmd.wr_move ? val_rd_ff : val_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_new || cmd.wr_move) key_mem[wr_addr] <= wr_key;
      if (cmd.wr_new || cmd.wr_move || cmd.wr_val) val_mem[wr_addr] <= wr_value;
      if (cmd.slot_rd) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_new)  fill_mem[bucket] <= fill_cur + FILL_W'(1);
      if (cmd.wr_move) fill_mem[bucket] <= fill_cur - FILL_W'(1);
      if (cmd.fill_rd) fill_rd_ff <= fill_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int i = 0; i < NUM_BUCKETS; i++) fill_vld_ff[i] <= 1'b0;
      end else if (cmd.wr_new || cmd.wr_move) begin
         fill_vld_ff[bucket] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_rd_vld_ff <= 1'b0;
         total_ff       <= '0;
         bit_cnt_ff     <= '0;
         rem_ff         <= '0;
         div_ff         <= CFG_W'(1);
      end else begin
         if (cmd.fill_rd) fill_rd_vld_ff <= fill_vld_ff[bucket];
         if (cmd.clear_all)    total_ff <= '0;
         else if (cmd.wr_new)  total_ff <= total_ff + TOT_W'(1);
         else if (cmd.wr_move) total_ff <= total_ff - TOT_W'(1);
         if (cmd.load) begin
            bit_cnt_ff <= CNT_W'(KEY_BITS);
            rem_ff     <= '0;
            div_ff     <= eff_div;
         end else if (cmd.div_step) begin
            bit_cnt_ff <= bit_cnt_ff - CNT_W'(1);
            rem_ff     <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= in_op;
         key_ff    <= in_key;
         key_sh_ff <= in_key;
         val_ff    <= in_value;
         way_ff    <= '0;
         found_ff  <= 1'b0;
         old_ff    <= '0;
         status_ff <= 1'b0;
      end else begin
         if (cmd.div_step) key_sh_ff <= {key_sh_ff[KEY_BITS-2:0], 1'b0};
         if (cmd.way_inc)  way_ff    <= way_ff + FILL_W'(1);
         if (cmd.hit) begin
            found_ff <= 1'b1;
            old_ff   <= val_rd_ff;
         end
         if (cmd.set_full) status_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_found       <= found_ff;
         out_old_value   <= OLDV_W'(old_ff);
         out_status      <= status_ff;
         out_entry_count <= CNT_OUT_W'(total_ff);
      end
   end

   assign sts.div_done  = (bit_cnt_ff == '0);
   assign sts.scan_end  = (way_ff == fill_cur);
   assign sts.match     = (key_rd_ff == key_ff);
   assign sts.fill_full = (fill_cur == FILL_W'(WAYS));
   assign sts.op        = op_ff;

   `CHT_ASSERT(a_rem_below_div, sts.div_done |-> (rem_ff < div_ff))
   `CHT_ASSERT(a_total_bound, 32'(total_ff) <= SLOTS)
   `CHT_ASSERT_NEXT(a_append_counts, cmd.wr_new, total_ff == TOT_W'($past(total_ff) + TOT_W'(1)))

endmodule

`default_nettype wire

[verif/chained_hash_table_engine_checker.sv]
// Checker for the chained hash table engine: watches req/rsp/csr, keeps its own
// copy of the table, predicts each response word and compares. Depends on cht_pkg.
`timescale 1ns / 1ps

module chained_hash_table_engine_checker import cht_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   input  wire              csr_wr_en,
   input  wire [CFG_W-1:0]  csr_wr_data,
   input  wire              req_tvalid,
   input  wire              req_tready,
   input  wire [63:0]       req_tdata,
   input  wire [1:0]        req_tuser,
   input  wire              rsp_tvalid,
   input  wire              rsp_tready,
   input  wire [RSP_W-1:0]  rsp_tdata,
   input  wire [0:0]        rsp_tuser,
   output int               fail_count,
   output int               pending,
   output int               rsp_seen,
   output int               full_seen,
   output int               hit_seen
);
   localparam int NB = NUM_BUCKETS_DEF;
   localparam int NW = WAYS_DEF;

   typedef struct packed {
      logic        found;
      logic [31:0] old_value;
      logic        status;
      logic [10:0] entry_count;
   } rsp_word_type;

   logic [31:0]  slot_key [NB*NW];
   logic [31:0]  slot_val [NB*NW];
   int           fill [NB];
   int           total;
   logic [8:0]   buckets;
   rsp_word_type rsp_expected [$];

   function automatic int bucket_of(logic [31:0] key);
      int n;
      n = (buckets == 0) ? 1 : ((buckets > NB) ? NB : buckets);
      return int'(key % n);
   endfunction

   function automatic rsp_word_type table_apply(op_type op, logic [31:0] key,
                                                logic [31:0] val);
      rsp_word_type r;
      int b, base, w, hit_way;
      r = '0;
      if (op == OP_CLEAR) begin
         foreach (fill[i]) fill[i] = 0;
         total = 0;
      end else begin
         b = bucket_of(key);
         base = b * NW;
         hit_way = -1;
         for (w = 0; w < fill[b]; w++)
            if (hit_way < 0 && slot_key[base+w] == key) hit_way = w;
         if (hit_way >= 0) begin
            r.found = 1'b1;
            r.old_value = slot_val[base+hit_way];
         end
         if (op == OP_PUT) begin
            if (hit_way >= 0) slot_val[base+hit_way] = val;
            else if (fill[b] < NW) begin
               slot_key[base+fill[b]] = key;
               slot_val[base+fill[b]] = val;
               fill[b]++;
               total++;
            end else r.status = 1'b1;
         end else if (op == OP_REMOVE && hit_way >= 0) begin
            // last entry of the bucket fills the hole
            slot_key[base+hit_way] = slot_key[base+fill[b]-1];
            slot_val[base+hit_way] = slot_val[base+fill[b]-1];
            fill[b]--;
            total--;
         end
      end
      r.entry_count = total[10:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         foreach (fill[i]) fill[i] = 0;
         total = 0;
         buckets = CFG_RESET;
         rsp_expected.delete();
         fail_count = 0;
         rsp_seen = 0;
         full_seen = 0;
         hit_seen = 0;
      end else begin
         if (csr_wr_en) buckets = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (rsp_expected.size() == 0)
               report_mismatch("unexpected word", rsp_tdata[31:0], 0);
            else begin
               e = rsp_expected.pop_front();
               if (e.status) full_seen++;
               if (e.found) hit_seen++;
               if (rsp_tdata[0] !== e.found) report_mismatch("found", rsp_tdata[0], e.found);
               if (rsp_tdata[32:1] !== e.old_value)
                  report_mismatch("old_value", rsp_tdata[32:1], e.old_value);
               if (rsp_tdata[43:33] !== e.entry_count)
                  report_mismatch("entry_count", rsp_tdata[43:33], e.entry_count);
               if (rsp_tdata[47:44] !== 4'd0) report_mismatch("pad", rsp_tdata[47:44], 0);
               if (rsp_tuser[0] !== e.status) report_mismatch("status", rsp_tuser[0], e.status);
            end
         end
         if (req_tvalid && req_tready)
            rsp_expected.push_back(table_apply(op_type'(req_tuser), req_tdata[31:0],
                                               req_tdata[63:32]));
      end
      pending = rsp_expected.size();
   end
endmodule

[verif/chained_hash_table_engine_tb.sv]
// Testbench top for the chained hash table engine: drives bursts of table ops
// and bucket-count changes, checker module scores responses. Depends on cht_pkg.
`timescale 1ns / 1ps

module chained_hash_table_engine_tb;
   import cht_pkg::*;

   localparam longint CYCLE_LIMIT = 2000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;
   logic             req_tvalid = 1'b0;
   wire              req_tready;
   logic [63:0]      req_tdata = '0;   // key, value
   logic [1:0]       req_tuser = '0;   // op
   wire              rsp_tvalid;
   logic             rsp_tready = 1'b0;
   wire [RSP_W-1:0]  rsp_tdata;        // found, old_value, entry_count, pad
   wire [0:0]        rsp_tuser;        // status
   int               fail_count, pending, rsp_seen, full_seen, hit_seen;
   longint           cycle_count = 0;
   logic [31:0]      recent_keys [16];
   int               burst_left = 0;

   always #10 clock = ~clock;

   chained_hash_table_engine uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   chained_hash_table_engine_checker scoreboard (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen),
      .full_seen(full_seen), .hit_seen(hit_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL chained_hash_table_engine");
         $finish;
      end
   end

   // receiver: stall pattern that switches between modes
   always @(negedge clock) begin
      case ((cycle_count / 3000) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((cycle_count % 97) > 60);
         default: rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   task automatic send_word(op_type op, logic [31:0] key, logic [31:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {val, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_buckets(logic [8:0] n);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_key(int span);
      logic [31:0] k;
      case ($urandom_range(0, 3))
         0: k = $urandom;
         1: k = recent_keys[$urandom_range(0, 15)];
         default: k = $urandom_range(0, span);
      endcase
      recent_keys[$urandom_range(0, 15)] = k;
      return k;
   endfunction

   task automatic random_phase(int count, int span);
      int r;
      op_type op;
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         op = (r < 35) ? OP_GET : (r < 75) ? OP_PUT : (r < 98) ? OP_REMOVE : OP_CLEAR;
         k = pick_key(span);
         send_word(op, k, $urandom);
      end
   endtask

   initial begin
      foreach (recent_keys[i]) recent_keys[i] = i;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: reset bucket count, fill one bucket past full, extreme fields
      send_word(OP_GET, 32'd5, 32'd0);
      send_word(OP_REMOVE, 32'd5, 32'd0);
      for (int i = 0; i < 5; i++) send_word(OP_PUT, 32'd7 + 256*i, 32'hFFFF_FFF0 + i);
      send_word(OP_PUT, 32'd7 + 512, 32'hFFFF_FFFF);
      send_word(OP_GET, 32'd7 + 256*4, 32'd0);
      send_word(OP_REMOVE, 32'd7, 32'd0);
      send_word(OP_GET, 32'd7 + 768, 32'd0);
      send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_PUT, 32'd0, 32'd0);
      send_word(OP_GET, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_GET, 32'd0, 32'd0);
      // no rehash: entries stay behind under a new count
      send_word(OP_PUT, 32'd300, 32'd1);
      set_buckets(9'd0);
      send_word(OP_GET, 32'd300, 32'd0);
      send_word(OP_PUT, 32'd301, 32'd2);
      set_buckets(9'd511);
      send_word(OP_GET, 32'd300, 32'd0);
      send_word(OP_REMOVE, 32'd301, 32'd0);
      send_word(OP_CLEAR, 32'd0, 32'd0);
      // random phases over several bucket counts
      set_buckets(9'd1);
      random_phase(200, 40);
      set_buckets(9'd256);
      random_phase(350, 3000);
      set_buckets(9'd3);
      random_phase(250, 60);
      set_buckets(9'd257);
      random_phase(300, 2000);
      set_buckets(9'($urandom_range(2, 255)));
      random_phase(300, 500);
      drain();
      random_phase(300, 1500);
      drain();
      $display("covered %0d responses, %0d hits, %0d full-bucket refusals",
               rsp_seen, hit_seen, full_seen);
      $display("bucket counts 0, 1, 3, 256, 257, 511 and one random setting");
      if (fail_count == 0) begin
         $display("PASS chained_hash_table_engine");
      end else begin
         $display("FAIL chained_hash_table_engine");
      end
      $finish;
   end
endmodule

[chained_hash_table_engine.f]
+incdir+sv
sv/cht_pkg.sv
sv/cht_ctrl.sv
sv/cht_dpath.sv
sv/chained_hash_table_engine.sv
verif/chained_hash_table_engine_checker.sv
verif/chained_hash_table_engine_tb.sv
